/* src/lif_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the leaky integrator dense layer.
// No dependencies; imported by every other file of the block.
package lif_pkg;

    localparam int INPUT_COUNT  = 16;
    localparam int NEURON_COUNT = 16;
    localparam int IN_IDX_W     = $clog2(INPUT_COUNT);
    localparam int NEU_IDX_W    = $clog2(NEURON_COUNT);

    localparam logic [15:0] DECAY_RESET = 16'd58982;

    typedef enum logic [1:0] {
        KIND_WEIGHT   = 2'd0,
        KIND_MEMBRANE = 2'd1,
        KIND_STEP     = 2'd2,
        KIND_UNUSED   = 2'd3
    } lif_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SHIFT,
        ST_ACCUM,
        ST_EMIT
    } lif_state_t;

    // Control shared by all lanes; per-lane write selects travel separately.
    typedef struct packed {
        logic [IN_IDX_W-1:0] wr_row;
        logic [31:0]         wr_value;
        logic [IN_IDX_W-1:0] rd_row;
        logic [15:0]         decay;
        logic                decay_apply;
        logic                accum_en;
    } lif_lane_ctrl_t;

    // Add with saturation to the signed 32-bit range.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return s[31:0];
    endfunction

    // Integer part of a Q16.16 value, truncated toward zero.
    function automatic logic signed [15:0] int_part(input logic signed [31:0] m);
        logic signed [32:0] biased;
        biased = {m[31], m} + (m[31] ? 33'sd65535 : 33'sd0);
        return biased[31:16];
    endfunction

endpackage

/* src/lif_lane.sv */
`timescale 1ns / 1ps
// One neuron lane: its weight column memory, membrane register, decay multiplier
// and saturating accumulator. Depends on lif_pkg.
module lif_lane
    import lif_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lif_lane_ctrl_t        ctrl,
    input  logic                  weight_sel,
    input  logic                  membrane_sel,
    output logic signed [31:0]    membrane
);

    logic [15:0]        weight_mem [INPUT_COUNT];
    logic [15:0]        rd_data_reg;
    logic signed [47:0] prod_reg;
    logic signed [31:0] membrane_reg;
    logic signed [31:0] membrane_next;
    logic signed [31:0] weight_q16;

    // Weight memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (weight_sel)
            weight_mem[ctrl.wr_row] <= ctrl.wr_value[15:0];
        rd_data_reg <= weight_mem[ctrl.rd_row];
        prod_reg    <= membrane_reg * $signed({1'b0, ctrl.decay});
    end

    assign weight_q16 = {{8{rd_data_reg[15]}}, rd_data_reg, 8'h00};

    always_comb
    begin
        priority if (membrane_sel)
            membrane_next = ctrl.wr_value;
        else if (ctrl.decay_apply)
            membrane_next = prod_reg[47:16];
        else if (ctrl.accum_en)
            membrane_next = sat_add(membrane_reg, weight_q16);
        else
            membrane_next = membrane_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            membrane_reg <= '0;
        else
            membrane_reg <= membrane_next;
    end

    assign membrane = membrane_reg;

endmodule

/* src/lif_merge.sv */
`timescale 1ns / 1ps
// Merging stage: picks one lane's membrane, takes its integer part and holds it
// in the output register. Depends on lif_pkg.
module lif_merge
    import lif_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [31:0]       lane_membrane [NEURON_COUNT],
    input  logic [NEU_IDX_W-1:0]     sel_idx,
    input  logic                     load,
    input  logic                     out_ready,
    output logic                     out_free,
    output logic                     out_valid,
    output logic [NEU_IDX_W-1:0]     neuron,
    output logic signed [15:0]       membrane_integer,
    output logic                     last
);

    logic                    valid_reg;
    logic [NEU_IDX_W-1:0]    neuron_reg;
    logic signed [15:0]      integer_reg;
    logic                    last_reg;

    assign out_free = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neuron_reg  <= sel_idx;
            integer_reg <= int_part(lane_membrane[sel_idx]);
            last_reg    <= (sel_idx == NEU_IDX_W'(NEURON_COUNT - 1));
        end
    end

    assign out_valid        = valid_reg;
    assign neuron           = neuron_reg;
    assign membrane_integer = integer_reg;
    assign last             = last_reg;

endmodule

/* src/leaky_integrator_dense_layer_unit.sv */
`timescale 1ns / 1ps
// Leaky integrator dense layer, 16 inputs by 16 neurons. Setup requests can follow
// back to back. A timestep request runs a multiply step, a shift step, a sweep of the
// 16 weight rows (one row read per cycle from the lane memories) and 16 emit steps;
// no request is taken until the last emit, and each emit waits while the output stalls.
// Reset (rst_n, async low) zeroes membranes, sets decay to 58982; weights stay unset.
module leaky_integrator_dense_layer_unit
    import lif_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  logic [15:0]         cfg_write_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [7:0]          address,
    input  logic signed [31:0]  write_value,
    input  logic [15:0]         spike_mask,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          neuron,
    output logic signed [15:0]  membrane_integer,
    output logic                last
);

    lif_state_t             state_reg, state_next;
    logic [IN_IDX_W-1:0]    cnt_reg, cnt_next;
    logic [15:0]            spike_reg, spike_next;
    logic [15:0]            decay_reg;

    logic                   accept;
    logic                   out_free;
    logic                   out_load;
    lif_lane_ctrl_t         ctrl;
    logic [NEURON_COUNT-1:0] weight_sel;
    logic [NEURON_COUNT-1:0] membrane_sel;
    logic signed [31:0]     lane_membrane [NEURON_COUNT];

    // Decay register: the user must write it only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decay_reg <= DECAY_RESET;
        else if (cfg_write_en)
            decay_reg <= cfg_write_data;
    end

    assign accept = in_valid && in_ready;

    // Setup writes: weight address splits into input row (high) and neuron lane (low)
    always_comb
    begin
        for (int n = 0; n < NEURON_COUNT; n++)
        begin
            weight_sel[n]   = accept && (kind == KIND_WEIGHT) &&
                              (address[NEU_IDX_W-1:0] == NEU_IDX_W'(n));
            membrane_sel[n] = accept && (kind == KIND_MEMBRANE) &&
                              (address == 8'(n));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            spike_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            spike_reg <= spike_next;
        end
    end

    // Sequencer: multiply, apply decay, sweep weight rows, then emit one neuron a cycle while the output is free
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        spike_next       = spike_reg;
        in_ready         = 1'b0;
        out_load         = 1'b0;
        ctrl.wr_row      = address[NEU_IDX_W +: IN_IDX_W];
        ctrl.wr_value    = write_value;
        ctrl.rd_row      = '0;
        ctrl.decay       = decay_reg;
        ctrl.decay_apply = 1'b0;
        ctrl.accum_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && kind == KIND_STEP)
                begin
                    spike_next = spike_mask;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // product registers in every lane this cycle
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                ctrl.decay_apply = 1'b1;
                ctrl.rd_row      = '0;
                cnt_next         = '0;
                state_next       = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                // row cnt is on the read port now; fetch the next one
                ctrl.accum_en = spike_reg[cnt_reg];
                ctrl.rd_row   = cnt_reg + 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == IN_IDX_W'(INPUT_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_load = out_free;
                if (out_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == IN_IDX_W'(NEURON_COUNT - 1))
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar n = 0; n < NEURON_COUNT; n++)
    begin : g_lane
        lif_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .weight_sel   (weight_sel[n]),
            .membrane_sel (membrane_sel[n]),
            .membrane     (lane_membrane[n])
        );
    end

    lif_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .lane_membrane    (lane_membrane),
        .sel_idx          (cnt_reg),
        .load             (out_load),
        .out_ready        (out_ready),
        .out_free         (out_free),
        .out_valid        (out_valid),
        .neuron           (neuron),
        .membrane_integer (membrane_integer),
        .last             (last)
    );

endmodule

/* src/lif_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the leaky integrator dense layer, bound to the top level.
// Depends on lif_pkg and leaky_integrator_dense_layer_unit.
module lif_checker
    import lif_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [1:0]          kind,
    input logic                out_valid,
    input logic                out_ready,
    input logic [3:0]          neuron,
    input logic signed [15:0]  membrane_integer,
    input logic                last
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(neuron) && $stable(membrane_integer) && $stable(last))
        else $error("stalled result changed");

    // Results of a timestep come in neuron order
    a_neuron_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last ##1 out_valid |-> neuron == $past(neuron) + 4'd1)
        else $error("neuron index skipped");

    // Last marks the final neuron only
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (neuron == 4'(NEURON_COUNT - 1))))
        else $error("last flag misplaced");

    // A timestep request keeps the block busy
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == KIND_STEP |=> !in_ready)
        else $error("request accepted during timestep");

endmodule

bind leaky_integrator_dense_layer_unit lif_checker u_lif_checker (.*);

/* bench/tb_leaky_integrator_dense_layer_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for leaky_integrator_dense_layer_unit: weight and membrane
// setup requests, timestep requests scored against an in-bench layer predictor.
// Depends on lif_pkg (kinds, sizes, decay reset value) and the unit itself.
module tb_leaky_integrator_dense_layer_unit;
    import lif_pkg::*;

    localparam int WEIGHT_DEPTH   = INPUT_COUNT * NEURON_COUNT;
    localparam int SETTLE_CYCLES  = 48;
    localparam int RANDOM_TARGET  = 150;
    localparam int DIRECTED_COUNT = 23;
    localparam longint MEMBRANE_MAX = 64'sh7FFF_FFFF;
    localparam longint MEMBRANE_MIN = -64'sh8000_0000;

    // One row of the directed table. Decay rows carry the factor in value[15:0].
    typedef struct packed {
        logic        is_decay;
        lif_kind_t   kind;
        logic [7:0]  address;
        logic [31:0] value;
        logic [15:0] mask;
        logic        typed;       // membrane_integer of every neuron is typed in
        logic [15:0] typed_int;
    } stim_row_t;

    typedef struct {
        logic [3:0]  neuron;
        logic [15:0] membrane_integer;
        logic        last;
    } membrane_report_t;

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [15:0] cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [1:0]  kind           = '0;
    logic [7:0]  address        = '0;
    logic [31:0] write_value    = '0;
    logic [15:0] spike_mask     = '0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [3:0]  neuron;
    logic [15:0] membrane_integer;
    logic        last;

    // Travel alongside the payload so the scoreboard sees them at acceptance.
    logic        expect_typed   = 1'b0;
    logic [15:0] typed_integer  = '0;

    // Bench copy of the layer state.
    logic signed [31:0] potential [NEURON_COUNT] = '{default: '0};
    logic [15:0]        weight_shadow [WEIGHT_DEPTH];
    logic [15:0]        decay_shadow = DECAY_RESET;

    membrane_report_t pending_membranes [$];
    int               mismatch_count = 0;
    bit               sender_eager   = 1'b0;
    bit               receiver_eager = 1'b0;

    // Directed table: reset state, register extremes, saturation both ways,
    // ignored kinds and addresses, dropped weight upper bits, truncation of
    // negative fractions toward zero, and single, alternating and full spike masks.
    stim_row_t directed_rows [DIRECTED_COUNT] = '{
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'h0000, 1'b1, 16'h0000},
        '{1'b1, KIND_STEP,     8'h00, 32'h0000_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h00, 32'h7FFF_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h01, 32'h8000_0000, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h0F, 32'h0001_8000, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h02, 32'hFFFF_0001, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h10, 32'h0000_BEEF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'hFF, 32'hFFFF_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_WEIGHT,   8'h00, 32'h0000_7FFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_WEIGHT,   8'hFF, 32'h0000_8000, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_WEIGHT,   8'h10, 32'hFFFF_7FFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_UNUSED,   8'h00, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'hFF, 32'hFFFF_FFFF, 16'h0001, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'h8000, 1'b0, 16'h0000},
        '{1'b1, KIND_STEP,     8'h00, 32'h0000_0000, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'h0000, 1'b1, 16'h0000},
        '{1'b1, KIND_STEP,     8'h00, {16'h0000, DECAY_RESET}, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h03, 32'hFFFE_FFFF, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_MEMBRANE, 8'h04, 32'h7FFF_0000, 16'h0000, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'hAAAA, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'h5555, 1'b0, 16'h0000},
        '{1'b0, KIND_STEP,     8'h00, 32'h0000_0000, 16'hFFFF, 1'b0, 16'h0000}
    };

    leaky_integrator_dense_layer_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .address          (address),
        .write_value      (write_value),
        .spike_mask       (spike_mask),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .neuron           (neuron),
        .membrane_integer (membrane_integer),
        .last             (last)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Update the layer state for one accepted request and queue the
    // membrane reports a timestep produces.
    function automatic void advance_layer(input lif_kind_t k, input logic [7:0] addr,
                                          input logic [31:0] value, input logic [15:0] mask,
                                          input logic typed, input logic [15:0] typed_int);
        longint           scaled;
        longint           total;
        longint           whole;
        membrane_report_t report;
        case (k)
            KIND_WEIGHT: weight_shadow[addr] = value[15:0];
            KIND_MEMBRANE:
                if (int'(addr) < NEURON_COUNT)
                    potential[addr[NEU_IDX_W-1:0]] = value;
            KIND_STEP: begin
                // Leak: floor of membrane * decay / 2^16.
                for (int n = 0; n < NEURON_COUNT; n++) begin
                    scaled = (longint'(potential[n]) * longint'(decay_shadow)) >>> 16;
                    potential[n] = scaled[31:0];
                end
                // Integrate row by row, saturating after every single add.
                for (int i = 0; i < INPUT_COUNT; i++) begin
                    if (mask[i]) begin
                        for (int n = 0; n < NEURON_COUNT; n++) begin
                            total = longint'(potential[n])
                                  + (longint'($signed(weight_shadow[i * NEURON_COUNT + n])) <<< 8);
                            if (total > MEMBRANE_MAX)
                                total = MEMBRANE_MAX;
                            else if (total < MEMBRANE_MIN)
                                total = MEMBRANE_MIN;
                            potential[n] = total[31:0];
                        end
                    end
                end
                for (int n = 0; n < NEURON_COUNT; n++) begin
                    whole = longint'(potential[n]);
                    whole = (whole < 0) ? -((-whole) >>> 16) : (whole >>> 16);
                    report.neuron           = 4'(n);
                    report.membrane_integer = typed ? typed_int : whole[15:0];
                    report.last             = (n == NEURON_COUNT - 1);
                    pending_membranes.push_back(report);
                end
            end
            default: ;   // unused kind: drop
        endcase
    endfunction

    function automatic void compare_membrane(input logic [3:0] got_neuron,
                                             input logic [15:0] got_int,
                                             input logic got_last);
        membrane_report_t want;
        if (pending_membranes.size() == 0) begin
            $error("unexpected result: neuron %0d membrane_integer %0d last %0b",
                   got_neuron, $signed(got_int), got_last);
            mismatch_count++;
            return;
        end
        want = pending_membranes.pop_front();
        if (got_neuron !== want.neuron) begin
            $error("neuron: expected %0d, actual %0d", want.neuron, got_neuron);
            mismatch_count++;
        end
        if (got_int !== want.membrane_integer) begin
            $error("membrane_integer: expected %0d, actual %0d",
                   $signed(want.membrane_integer), $signed(got_int));
            mismatch_count++;
        end
        if (got_last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got_last);
            mismatch_count++;
        end
    endfunction

    // Scoreboard: sample pre-edge values; score results before predicting so a
    // request accepted on the same edge cannot mask a stray result.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            compare_membrane(neuron, membrane_integer, last);
        if (rst_n && cfg_write_en)
            decay_shadow = cfg_write_data;
        if (rst_n && in_valid && in_ready)
            advance_layer(lif_kind_t'(kind), address, write_value, spike_mask,
                          expect_typed, typed_integer);
    end

    // Present one request after a random gap and hold it until accepted.
    // Valid stays high on return; the caller either presents the next request
    // in the same step or drops valid.
    task automatic issue_request(input lif_kind_t k, input logic [7:0] addr,
                                 input logic [31:0] value, input logic [15:0] mask,
                                 input logic typed, input logic [15:0] typed_int);
        int gap;
        gap = sender_eager ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        kind          <= k;
        address       <= addr;
        write_value   <= value;
        spike_mask    <= mask;
        expect_typed  <= typed;
        typed_integer <= typed_int;
        do @(posedge clk); while (!in_ready);
    endtask

    // Drain the unit, let it go quiet, then write the decay register.
    task automatic set_decay(input logic [15:0] factor);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_membranes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= factor;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Result side: stall a random number of cycles before each result,
    // or none at all while the receiver runs eager.
    initial begin
        int stall;
        forever begin
            stall = receiver_eager ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && rst_n));
        end
    end

    // Request side: reset, preload every weight, walk the directed table,
    // then random bursts split into phases by decay changes.
    initial begin
        int          random_requests;
        int          burst;
        logic [15:0] factor;
        logic [31:0] level;
        random_requests = 0;
        burst           = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Preload the whole weight store so no timestep reads an unwritten entry.
        for (int a = 0; a < WEIGHT_DEPTH; a++)
            issue_request(KIND_WEIGHT, 8'(a), 32'($urandom), 16'h0000, 1'b0, 16'h0000);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_decay)
                set_decay(directed_rows[r].value[15:0]);
            else
                issue_request(directed_rows[r].kind, directed_rows[r].address,
                              directed_rows[r].value, directed_rows[r].mask,
                              directed_rows[r].typed, directed_rows[r].typed_int);
        end

        while (random_requests < RANDOM_TARGET) begin
            sender_eager   = ($urandom_range(0, 4) == 0);
            receiver_eager = ($urandom_range(0, 4) == 0);
            // Every eighth burst opens a new phase at a fresh decay setting.
            if (burst % 8 == 7) begin
                case ($urandom_range(0, 3))
                    0:       factor = 16'h0000;
                    1:       factor = 16'hFFFF;
                    2:       factor = DECAY_RESET;
                    default: factor = 16'($urandom_range(0, 65535));
                endcase
                set_decay(factor);
            end
            if ($urandom_range(0, 9) < 8) begin
                // Well-formed burst: a few setup writes, then timesteps.
                repeat ($urandom_range(0, 4)) begin
                    issue_request(KIND_WEIGHT, 8'($urandom_range(0, 255)), 32'($urandom),
                                  16'($urandom_range(0, 65535)), 1'b0, 16'h0000);
                    random_requests++;
                end
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 5))
                        0:       level = 32'h7FFF_FFFF;
                        1:       level = 32'h8000_0000;
                        2:       level = 32'($signed(21'($urandom)));
                        default: level = 32'($urandom);
                    endcase
                    issue_request(KIND_MEMBRANE, 8'($urandom_range(0, NEURON_COUNT - 1)),
                                  level, 16'($urandom_range(0, 65535)), 1'b0, 16'h0000);
                    random_requests++;
                end
                repeat ($urandom_range(1, 3)) begin
                    case ($urandom_range(0, 7))
                        0:       factor = 16'h0000;
                        1:       factor = 16'hFFFF;
                        default: factor = 16'($urandom_range(0, 65535));
                    endcase
                    issue_request(KIND_STEP, 8'($urandom_range(0, 255)), 32'($urandom),
                                  factor, 1'b0, 16'h0000);
                    random_requests++;
                end
            end else begin
                // Noise: unused kind and out-of-range membrane writes, both dropped.
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) == 0)
                        issue_request(KIND_UNUSED, 8'($urandom_range(0, 255)),
                                      32'($urandom), 16'($urandom_range(0, 65535)),
                                      1'b0, 16'h0000);
                    else
                        issue_request(KIND_MEMBRANE, 8'($urandom_range(NEURON_COUNT, 255)),
                                      32'($urandom), 16'($urandom_range(0, 65535)),
                                      1'b0, 16'h0000);
                end
            end
            burst++;
        end

        // Drop valid, wait out every queued report, then watch for strays.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_membranes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: roughly ten times the slowest legal run.
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
